>>> rtl/gds_pkg.sv
package gds_pkg;

    localparam int PIXELS      = 4096;
    localparam int CHANNELS    = 4;
    localparam int PIX_W       = $clog2(PIXELS);
    localparam int CH_W        = $clog2(CHANNELS);
    localparam int ADDR_W      = PIX_W + CH_W;
    localparam int STORE_DEPTH = PIXELS * CHANNELS;
    localparam int DATA_W      = 32;
    localparam int THRESH_W    = 31;
    localparam int COUNT_W     = 13;
    localparam int ENERGY_W    = 47;
    localparam int DIFF_W      = DATA_W + 1;
    localparam int PROD_W      = DIFF_W + DATA_W;
    localparam int FRAC_W      = 16;
    localparam int D_W         = PROD_W - FRAC_W;
    localparam int SUM_W       = D_W + 1;
    localparam int MAG_W       = D_W - 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

    typedef enum logic
    {
        CMD_LOAD    = 1'b0,
        CMD_PROCESS = 1'b1
    } cmd_t;

    typedef enum logic
    {
        CFG_THRESHOLD   = 1'b0,
        CFG_PIXEL_COUNT = 1'b1
    } cfg_index_t;

    // operand carries the pixel value on loads and the edge weight on process beats
    typedef struct packed
    {
        cmd_t                     kind;
        logic                     err;
        logic [ADDR_W-1:0]        addr_a;
        logic [ADDR_W-1:0]        addr_b;
        logic signed [DATA_W-1:0] operand;
        logic signed [DATA_W-1:0] bregman;
        logic                     last;
    } item_t;

    typedef struct packed
    {
        logic  empty;
        item_t head;
    } queue_status_t;

endpackage

>>> rtl/gds_if.sv
interface gds_in_if;
    import gds_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [PIX_W-1:0]         first_pixel;
    logic [PIX_W-1:0]         second_pixel;
    logic [CH_W-1:0]          channel;
    logic signed [DATA_W-1:0] pixel_value;
    logic signed [DATA_W-1:0] edge_weight;
    logic signed [DATA_W-1:0] bregman_in;
    logic                     last_item;

    modport source
    (
        output valid, cmd, first_pixel, second_pixel, channel,
        output pixel_value, edge_weight, bregman_in, last_item,
        input  ready
    );

    modport sink
    (
        input  valid, cmd, first_pixel, second_pixel, channel,
        input  pixel_value, edge_weight, bregman_in, last_item,
        output ready
    );
endinterface

interface gds_out_if;
    import gds_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] shrunk_value;
    logic signed [DATA_W-1:0] residual_value;
    logic [ENERGY_W-1:0]      energy_sum;
    logic                     index_error;
    logic                     last_result;

    modport source
    (
        output valid, shrunk_value, residual_value, energy_sum, index_error, last_result,
        input  ready
    );

    modport sink
    (
        input  valid, shrunk_value, residual_value, energy_sum, index_error, last_result,
        output ready
    );
endinterface

>>> rtl/graph_difference_shrink.sv
// Soft-threshold shrinkage of weighted graph differences. Load beats (cmd 0) write a signed
// Q16.16 value into a 4096 x 4 pixel store and give no result; process beats (cmd 1) give one
// result: d = weight * (Y[a] - Y[b]) floored to Q33.16, s = d + bregman_in saturated to 32 bits,
// the shrunk value, the residual and a saturating running sum of |d| that clears after a beat
// marked last. A pixel index at or beyond pixel_count flags index_error with zero values and the
// sum unchanged. One beat is taken per clock while the output is not held; each result
// passes through the registered store read, difference, 33 x 32 multiply, sum/saturate and
// shrink/accumulate stages. A four-entry queue sits between the input classifier and the
// pipe, so input keeps flowing until the queue fills while a result waits at the output.
// Store entries never loaded read as unknown.
module graph_difference_shrink
(
    input  logic                          clk,
    input  logic                          rst_n,
    gds_in_if.sink                        in_ch,
    gds_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [gds_pkg::THRESH_W-1:0]  cfg_data
);
    import gds_pkg::*;

    logic [THRESH_W-1:0] threshold_reg;
    logic [COUNT_W-1:0]  pixel_count_reg;
    logic                queue_full;
    logic                push;
    item_t               push_item;
    logic                pop;
    queue_status_t       status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= '0;
            pixel_count_reg <= COUNT_W'(PIXELS);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_THRESHOLD)
            begin
                threshold_reg <= cfg_data;
            end
            else
            begin
                pixel_count_reg <= cfg_data[COUNT_W-1:0];
            end
        end
    end

    gds_front u_front
    (
        .in_ch       (in_ch),
        .pixel_count (pixel_count_reg),
        .queue_full  (queue_full),
        .push        (push),
        .item        (push_item)
    );

    gds_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (queue_full),
        .status    (status)
    );

    gds_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .pop       (pop),
        .threshold (threshold_reg),
        .out_ch    (out_ch)
    );
endmodule

>>> rtl/gds_front.sv
module gds_front
(
    gds_in_if.sink                      in_ch,
    input  logic [gds_pkg::COUNT_W-1:0] pixel_count,
    input  logic                        queue_full,
    output logic                        push,
    output gds_pkg::item_t              item
);
    import gds_pkg::*;

    logic is_process;
    logic a_out;
    logic b_out;

    assign in_ch.ready = !queue_full;
    assign push        = in_ch.valid && !queue_full;

    // pixel indices are narrower than the count, so a count above PIXELS caps itself
    assign is_process = (in_ch.cmd == CMD_PROCESS);
    assign a_out      = ({1'b0, in_ch.first_pixel} >= pixel_count);
    assign b_out      = ({1'b0, in_ch.second_pixel} >= pixel_count);

    always_comb
    begin
        item.kind    = is_process ? CMD_PROCESS : CMD_LOAD;
        item.err     = is_process && (a_out || b_out);
        item.addr_a  = {in_ch.first_pixel, in_ch.channel};
        item.addr_b  = {in_ch.second_pixel, in_ch.channel};
        item.operand = is_process ? in_ch.edge_weight : in_ch.pixel_value;
        item.bregman = in_ch.bregman_in;
        item.last    = in_ch.last_item;
    end
endmodule

>>> rtl/gds_queue.sv
module gds_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  gds_pkg::item_t         push_item,
    input  logic                   pop,
    output logic                   full,
    output gds_pkg::queue_status_t status
);
    import gds_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign full         = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.head  = entry_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && !status.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule

>>> rtl/gds_back.sv
module gds_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  gds_pkg::queue_status_t       status,
    output logic                         pop,
    input  logic [gds_pkg::THRESH_W-1:0] threshold,
    gds_out_if.source                    out_ch
);
    import gds_pkg::*;

    logic [DATA_W-1:0] store_mem [STORE_DEPTH];

    logic advance;
    logic take;

    // stage 1: store read
    logic                     v1_reg, err1_reg, last1_reg;
    logic signed [DATA_W-1:0] w1_reg, breg1_reg;
    logic [DATA_W-1:0]        rd_a_reg, rd_b_reg;
    // stage 2: difference
    logic                     v2_reg, err2_reg, last2_reg;
    logic signed [DATA_W-1:0] w2_reg, breg2_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    // stage 3: product
    logic                     v3_reg, err3_reg, last3_reg;
    logic signed [DATA_W-1:0] breg3_reg;
    logic signed [PROD_W-1:0] prod_reg;
    // stage 4: saturated sum and magnitude
    logic                     v4_reg, err4_reg, last4_reg;
    logic signed [DATA_W-1:0] sum4_reg;
    logic [MAG_W-1:0]         mag4_reg;
    // output register
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] shrunk_reg, residual_reg;
    logic [ENERGY_W-1:0]      energy_out_reg;
    logic                     err_out_reg, last_out_reg;
    logic [ENERGY_W-1:0]      energy_reg;
    logic [ENERGY_W-1:0]      energy_next;

    logic signed [D_W-1:0]    d_val;
    logic signed [SUM_W-1:0]  s_full;
    logic signed [DATA_W-1:0] s_sat;
    logic [D_W-1:0]           d_abs;
    logic signed [DIFF_W-1:0] s_ext;
    logic signed [DIFF_W-1:0] t_ext;
    logic signed [DIFF_W-1:0] shr_wide;
    logic signed [DIFF_W-1:0] res_wide;
    logic [ENERGY_W+1:0]      energy_add;
    logic [ENERGY_W-1:0]      energy_new;

    // the whole pipe holds while a finished beat waits at the output
    assign advance = !out_valid_reg || out_ch.ready;
    assign pop     = advance;
    assign take    = advance && !status.empty;

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.shrunk_value   = shrunk_reg;
    assign out_ch.residual_value = residual_reg;
    assign out_ch.energy_sum     = energy_out_reg;
    assign out_ch.index_error    = err_out_reg;
    assign out_ch.last_result    = last_out_reg;

    // loads write and process beats read in the same stage, so order is kept
    always_ff @(posedge clk)
    begin
        if (take && status.head.kind == CMD_LOAD)
        begin
            store_mem[status.head.addr_a] <= status.head.operand;
        end
        if (advance)
        begin
            rd_a_reg <= store_mem[status.head.addr_a];
            rd_b_reg <= store_mem[status.head.addr_b];
        end
    end

    always_comb
    begin
        d_val  = prod_reg[PROD_W-1:FRAC_W];
        s_full = SUM_W'(d_val) + SUM_W'(breg3_reg);
        if (s_full > SUM_W'(signed'({1'b0, {(DATA_W-1){1'b1}}})))
        begin
            s_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (s_full < -SUM_W'(signed'({1'b0, 1'b1, {(DATA_W-1){1'b0}}})))
        begin
            s_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            s_sat = s_full[DATA_W-1:0];
        end
        d_abs = d_val[D_W-1] ? D_W'(-d_val) : D_W'(d_val);
    end

    always_comb
    begin
        s_ext = DIFF_W'(sum4_reg);
        t_ext = signed'({2'b00, threshold});
        if (s_ext > t_ext)
        begin
            shr_wide = s_ext - t_ext;
        end
        else if (s_ext < -t_ext)
        begin
            shr_wide = s_ext + t_ext;
        end
        else
        begin
            shr_wide = '0;
        end
        res_wide = s_ext - shr_wide;

        energy_add = (ENERGY_W+2)'(energy_reg) + (ENERGY_W+2)'(err4_reg ? '0 : mag4_reg);
        energy_new = (energy_add > (ENERGY_W+2)'(ENERGY_MAX)) ? ENERGY_MAX
                                                              : energy_add[ENERGY_W-1:0];
        energy_next = energy_reg;
        if (advance && v4_reg)
        begin
            energy_next = last4_reg ? '0 : energy_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            energy_reg    <= '0;
        end
        else
        begin
            energy_reg <= energy_next;
            if (advance)
            begin
                v1_reg        <= take && status.head.kind == CMD_PROCESS;
                v2_reg        <= v1_reg;
                v3_reg        <= v2_reg;
                v4_reg        <= v3_reg;
                out_valid_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            err1_reg  <= status.head.err;
            last1_reg <= status.head.last;
            w1_reg    <= status.head.operand;
            breg1_reg <= status.head.bregman;

            err2_reg  <= err1_reg;
            last2_reg <= last1_reg;
            w2_reg    <= w1_reg;
            breg2_reg <= breg1_reg;
            diff_reg  <= DIFF_W'(signed'(rd_a_reg)) - DIFF_W'(signed'(rd_b_reg));

            err3_reg  <= err2_reg;
            last3_reg <= last2_reg;
            breg3_reg <= breg2_reg;
            prod_reg  <= PROD_W'(diff_reg) * PROD_W'(w2_reg);

            err4_reg  <= err3_reg;
            last4_reg <= last3_reg;
            sum4_reg  <= s_sat;
            mag4_reg  <= d_abs[MAG_W-1:0];

            err_out_reg    <= err4_reg;
            last_out_reg   <= last4_reg;
            shrunk_reg     <= err4_reg ? '0 : shr_wide[DATA_W-1:0];
            residual_reg   <= err4_reg ? '0 : res_wide[DATA_W-1:0];
            energy_out_reg <= err4_reg ? energy_reg : energy_new;
        end
    end
endmodule

>>> test/testbench.sv
module testbench;
    import gds_pkg::*;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 200;
    localparam int DIRECTED_ROWS = 25;

    localparam longint SUM_MAX = 64'sh7FFF_FFFF;
    localparam longint SUM_MIN = -64'sh8000_0000;

    typedef struct packed
    {
        cmd_t                     cmd;
        logic [PIX_W-1:0]         pa;
        logic [PIX_W-1:0]         pb;
        logic [CH_W-1:0]          ch;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] weight;
        logic signed [DATA_W-1:0] breg;
        logic                     last;
    } beat_t;

    typedef struct packed
    {
        logic signed [DATA_W-1:0] shrunk;
        logic signed [DATA_W-1:0] residual;
        logic [ENERGY_W-1:0]      energy;
        logic                     err;
        logic                     last;
    } result_t;

    typedef struct packed
    {
        bit                    is_cfg;
        cfg_index_t            sel;
        logic [THRESH_W-1:0]   reg_val;
        beat_t                 beat;
        bit                    typed;
        result_t               want;
    } row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_index;
    logic [THRESH_W-1:0] cfg_data;

    gds_in_if  in_if();
    gds_out_if out_if();

    graph_difference_shrink i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_if),
        .out_ch    (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the block: store, running energy and both registers
    logic signed [DATA_W-1:0] pixel_mem [STORE_DEPTH];
    bit                       pixel_loaded [STORE_DEPTH];
    longint unsigned          energy_acc = 0;
    logic [THRESH_W-1:0]      shrink_level = '0;
    logic [COUNT_W-1:0]       pixel_limit = COUNT_W'(PIXELS);

    result_t pending_results[$];
    result_t oldest;
    int      mismatch_count = 0;
    int      cycle_count = 0;
    bit      steady_flow = 1'b0;
    bit      hold_request = 1'b0;
    int      hold_left = 0;
    row_t    directed [DIRECTED_ROWS];

    always #5 clk = ~clk;

    function automatic bit shrink_edge(input beat_t b, output result_t r);
        int unsigned lim;
        int unsigned ia;
        int unsigned ib;
        longint      ya;
        longint      yb;
        longint      d;
        longint      s;
        longint      t;
        longint      shr;
        bit          bad;
        r = '0;
        ia = b.pa * CHANNELS + b.ch;
        ib = b.pb * CHANNELS + b.ch;
        if (b.cmd == CMD_LOAD)
        begin
            pixel_mem[ia] = b.value;
            pixel_loaded[ia] = 1'b1;
            return 1'b0;
        end
        lim = (pixel_limit < PIXELS) ? pixel_limit : PIXELS;
        bad = (b.pa >= lim) || (b.pb >= lim) || (b.ch >= CHANNELS);
        if (!bad)
        begin
            ya = longint'(pixel_mem[ia]);
            yb = longint'(pixel_mem[ib]);
            // floor of the Q33.32 product back to Q33.16
            d = (longint'($signed(b.weight)) * (ya - yb)) >>> FRAC_W;
            s = d + longint'($signed(b.breg));
            if (s > SUM_MAX)
                s = SUM_MAX;
            else if (s < SUM_MIN)
                s = SUM_MIN;
            t = longint'(shrink_level);
            if (s > t)
                shr = s - t;
            else if (s < -t)
                shr = s + t;
            else
                shr = 0;
            r.shrunk = shr[DATA_W-1:0];
            r.residual = DATA_W'(s - shr);
            energy_acc += (d < 0) ? -d : d;
            if (energy_acc > ENERGY_MAX)
                energy_acc = 64'(ENERGY_MAX);
        end
        r.energy = energy_acc[ENERGY_W-1:0];
        r.err = bad;
        r.last = b.last;
        if (b.last)
            energy_acc = 0;
        return 1'b1;
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            // within +-2.0 so that the threshold band matters
            2, 3, 4: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input int unsigned lim);
        int unsigned span;
        if (lim == 0)
            return PIX_W'($urandom_range(PIXELS - 1));
        span = (lim < 64) ? lim : 64;
        case ($urandom_range(9))
            0: return PIX_W'(lim - 1);
            1, 2, 3: return PIX_W'($urandom_range(lim - 1));
            default: return PIX_W'($urandom_range(span - 1));
        endcase
    endfunction

    function automatic row_t load_row(input int pix, input int ch, input logic [DATA_W-1:0] v);
        row_t r;
        r = '0;
        r.beat.cmd = CMD_LOAD;
        r.beat.pa = PIX_W'(pix);
        r.beat.ch = CH_W'(ch);
        r.beat.value = v;
        return r;
    endfunction

    function automatic row_t proc_row(input int pa, input int pb, input int ch,
                                      input logic [DATA_W-1:0] w,
                                      input logic [DATA_W-1:0] breg, input bit last);
        row_t r;
        r = '0;
        r.beat.cmd = CMD_PROCESS;
        r.beat.pa = PIX_W'(pa);
        r.beat.pb = PIX_W'(pb);
        r.beat.ch = CH_W'(ch);
        r.beat.weight = w;
        r.beat.breg = breg;
        r.beat.last = last;
        return r;
    endfunction

    function automatic row_t cfg_row(input cfg_index_t sel, input logic [THRESH_W-1:0] v);
        row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.sel = sel;
        r.reg_val = v;
        return r;
    endfunction

    function automatic row_t with_result(input row_t r, input result_t want);
        row_t o;
        o = r;
        o.typed = 1'b1;
        o.want = want;
        return o;
    endfunction

    function automatic void check_field(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
        end
    endfunction

    task automatic send_beat(input beat_t b, input bit typed, input result_t want);
        result_t got;
        while (!steady_flow && $urandom_range(99) < 14)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.cmd <= b.cmd;
        in_if.first_pixel <= b.pa;
        in_if.second_pixel <= b.pb;
        in_if.channel <= b.ch;
        in_if.pixel_value <= b.value;
        in_if.edge_weight <= b.weight;
        in_if.bregman_in <= b.breg;
        in_if.last_item <= b.last;
        @(posedge clk);
        while (in_if.ready !== 1'b1)
            @(posedge clk);
        if (shrink_edge(b, got))
            pending_results.push_back(typed ? want : got);
    endtask

    task automatic write_reg(input cfg_index_t sel, input logic [THRESH_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == CFG_THRESHOLD)
            shrink_level = v;
        else
            pixel_limit = v[COUNT_W-1:0];
        @(posedge clk);
    endtask

    // loads leave no result behind, so allow the pipe to empty after the last one
    task automatic settle();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic fill_pixel(input logic [PIX_W-1:0] pix, input logic [CH_W-1:0] ch);
        beat_t b;
        if (!pixel_loaded[pix * CHANNELS + ch])
        begin
            b = '0;
            b.cmd = CMD_LOAD;
            b.pa = pix;
            b.pb = PIX_W'($urandom());
            b.ch = ch;
            b.value = pick_word();
            b.last = 1'($urandom_range(1));
            send_beat(b, 1'b0, '0);
        end
    endtask

    task automatic random_item();
        beat_t       b;
        int unsigned lim;
        bit          bad;
        lim = (pixel_limit < PIXELS) ? pixel_limit : PIXELS;
        b.cmd = CMD_PROCESS;
        b.pa = pick_pixel(lim);
        b.pb = pick_pixel(lim);
        b.ch = CH_W'($urandom_range(CHANNELS - 1));
        b.value = pick_word();
        b.weight = pick_word();
        b.breg = pick_word();
        b.last = ($urandom_range(9) == 0);
        if ($urandom_range(99) < 20)
        begin
            b.cmd = CMD_LOAD;
            b.pa = pick_pixel(PIXELS);
            send_beat(b, 1'b0, '0);
        end
        else
        begin
            bad = (lim == 0) || (lim < PIXELS && $urandom_range(99) < 15);
            if (bad && lim > 0)
            begin
                case ($urandom_range(2))
                    0: b.pa = PIX_W'($urandom_range(PIXELS - 1, lim));
                    1: b.pb = PIX_W'($urandom_range(PIXELS - 1, lim));
                    default:
                    begin
                        b.pa = PIX_W'($urandom_range(PIXELS - 1, lim));
                        b.pb = PIX_W'($urandom_range(PIXELS - 1, lim));
                    end
                endcase
            end
            // an edge only ever reads entries that were loaded
            if (b.pa < lim)
                fill_pixel(b.pa, b.ch);
            if (b.pb < lim)
                fill_pixel(b.pb, b.ch);
            send_beat(b, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL graph_difference_shrink");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, got %h %h %h %b %b",
                         $time, out_if.shrunk_value, out_if.residual_value,
                         out_if.energy_sum, out_if.index_error, out_if.last_result);
            end
            else
            begin
                oldest = pending_results.pop_front();
                check_field("shrunk_value", oldest.shrunk, out_if.shrunk_value);
                check_field("residual_value", oldest.residual, out_if.residual_value);
                check_field("energy_sum", oldest.energy, out_if.energy_sum);
                check_field("index_error", oldest.err, out_if.index_error);
                check_field("last_result", oldest.last, out_if.last_result);
            end
        end
    end

    // result side: random back-pressure plus one long hold-off on request
    initial
    begin
        out_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_if.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_if.ready <= 1'b0;
            end
            else
                out_if.ready <= steady_flow || ($urandom_range(99) >= 14);
        end
    end

    initial
    begin
        int                  items;
        logic [THRESH_W-1:0] level;
        logic [THRESH_W-1:0] count;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_THRESHOLD;
        cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.cmd = CMD_LOAD;
        in_if.first_pixel = '0;
        in_if.second_pixel = '0;
        in_if.channel = '0;
        in_if.pixel_value = '0;
        in_if.edge_weight = '0;
        in_if.bregman_in = '0;
        in_if.last_item = 1'b0;

        directed = '{
            load_row(0, 0, 32'h7FFF_FFFF),
            load_row(4095, 0, 32'h8000_0000),
            load_row(0, 3, 32'h0000_0000),
            load_row(4095, 3, 32'h0001_0000),
            // largest products: the running energy saturates
            proc_row(0, 4095, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0),
            proc_row(4095, 0, 0, 32'h8000_0000, 32'h8000_0000, 1'b0),
            with_result(proc_row(0, 0, 3, 32'h7FFF_FFFF, 32'h0, 1'b1),
                        '{32'h0, 32'h0, ENERGY_MAX, 1'b0, 1'b1}),
            with_result(proc_row(0, 4095, 3, 32'h0001_0000, 32'h0, 1'b1),
                        '{32'hFFFF_0000, 32'h0, 47'h1_0000, 1'b0, 1'b1}),
            cfg_row(CFG_THRESHOLD, 31'h0002_0000),
            load_row(1, 1, 32'h0003_0000),
            load_row(2, 1, 32'h0000_0000),
            // above, below and inside the band of 2.0
            with_result(proc_row(1, 2, 1, 32'h0001_0000, 32'h0, 1'b0),
                        '{32'h0001_0000, 32'h0002_0000, 47'h3_0000, 1'b0, 1'b0}),
            with_result(proc_row(2, 1, 1, 32'h0001_0000, 32'h0, 1'b0),
                        '{32'hFFFF_0000, 32'hFFFE_0000, 47'h6_0000, 1'b0, 1'b0}),
            with_result(proc_row(1, 1, 1, 32'h0001_0000, 32'h0001_8000, 1'b1),
                        '{32'h0, 32'h0001_8000, 47'h6_0000, 1'b0, 1'b1}),
            cfg_row(CFG_THRESHOLD, 31'h7FFF_FFFF),
            proc_row(0, 4095, 0, 32'h0001_0000, 32'h0, 1'b0),
            proc_row(4095, 0, 0, 32'h0001_0000, 32'h0, 1'b1),
            cfg_row(CFG_PIXEL_COUNT, 31'd1),
            with_result(proc_row(0, 4095, 0, 32'h0001_0000, 32'h1234, 1'b0),
                        '{32'h0, 32'h0, 47'h0, 1'b1, 1'b0}),
            with_result(proc_row(0, 0, 0, 32'h0001_0000, 32'h5, 1'b1),
                        '{32'h0, 32'h5, 47'h0, 1'b0, 1'b1}),
            cfg_row(CFG_PIXEL_COUNT, 31'd0),
            with_result(proc_row(0, 0, 0, 32'h0, 32'h0, 1'b1),
                        '{32'h0, 32'h0, 47'h0, 1'b1, 1'b1}),
            cfg_row(CFG_PIXEL_COUNT, 31'd8191),
            cfg_row(CFG_THRESHOLD, 31'h0),
            proc_row(4095, 0, 3, 32'h8000_0000, 32'h1234_5678, 1'b1)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
            begin
                settle();
                write_reg(directed[i].sel, directed[i].reg_val);
            end
            else
                send_beat(directed[i].beat, directed[i].typed, directed[i].want);
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            settle();
            steady_flow = 1'b0;
            items = 110;
            case (ph)
                0:
                begin
                    level = '0;
                    count = THRESH_W'(PIXELS);
                end
                1:
                begin
                    level = 31'h7FFF_FFFF;
                    count = 8191;
                end
                2:
                begin
                    level = THRESH_W'($urandom_range(32'h0004_0000));
                    count = THRESH_W'($urandom_range(32, 1));
                    hold_request = 1'b1;
                end
                3:
                begin
                    level = THRESH_W'($urandom());
                    count = THRESH_W'(PIXELS);
                    steady_flow = 1'b1;
                end
                4:
                begin
                    level = THRESH_W'($urandom_range(32'h0004_0000));
                    count = 1;
                end
                5:
                begin
                    level = 31'h0001_0000;
                    count = THRESH_W'($urandom_range(PIXELS - 1, 33));
                end
                6:
                begin
                    // every edge is out of range
                    level = '0;
                    count = 0;
                    items = 60;
                end
                default:
                begin
                    level = THRESH_W'($urandom_range(32'h0004_0000));
                    count = THRESH_W'(PIXELS - 1);
                end
            endcase
            write_reg(CFG_THRESHOLD, level);
            write_reg(CFG_PIXEL_COUNT, count);
            repeat (items) random_item();
        end

        settle();
        if (mismatch_count == 0)
            $display("PASS graph_difference_shrink");
        else
            $display("FAIL graph_difference_shrink");
        $finish;
    end

endmodule
